/* rtl/grm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg: shared types, constants and trig table for the column ray marcher
// Holds the sequencer state type, register indexes, default parameters and
// the Q1.16 quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int CELL_SIZE_DEF    = 64;
  localparam int GRID_DIM_DEF     = 10;
  localparam int SCREEN_ROWS_DEF  = 640;
  localparam int COLUMN_WIDTH_DEF = 10;

  localparam int HALF_FAN     = 60;
  localparam int HEIGHT_SCALE = 30;
  localparam int START_OFFSET = 5;
  localparam int MAP_BITS     = 100;
  localparam int POS_W        = 29;   // signed Q12.16 with headroom
  localparam int TRIG_W       = 18;   // signed Q1.16
  localparam int ANG_W        = 10;
  localparam int IDX_W        = 7;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  localparam logic [2:0] REG_VIEW     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] REG_MAP_LOW  = 3'd3;
  localparam logic [2:0] REG_MAP_HIGH = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARCH,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_SQRT,
    ST_MUL_D,
    ST_DIV_CHK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef logic [16:0] sq_tab_t [181];

  // reciprocals for exact floor division; products stay far below 2^shift
  localparam int TAYLOR_SH = 48;
  localparam int ANGLE_SH  = 52;
  localparam longint unsigned TAYLOR_RECIP [8] = '{
    (64'd1 << TAYLOR_SH) / 64'd6   + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd20  + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd42  + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd72  + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd110 + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd156 + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd210 + 64'd1,
    (64'd1 << TAYLOR_SH) / 64'd272 + 64'd1
  };
  localparam longint unsigned ANGLE_RECIP = (64'd1 << ANGLE_SH) / 64'd360 + 64'd1;

  // Taylor series in Q2.30, rounded to Q1.16
  function automatic sq_tab_t build_sq_tab();
    sq_tab_t tab;
    longint unsigned x;
    longint unsigned t;
    longint sum;
    logic [127:0] wide;
    for (int k = 0; k <= 180; k++) begin
      wide = (128'(k) * 128'(64'd3373259426) + 128'd180) * 128'(ANGLE_RECIP);
      x = 64'(wide >> ANGLE_SH);
      t = x;
      sum = longint'(x);
      for (int n = 0; n < 8; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        wide = 128'(t) * 128'(TAYLOR_RECIP[n]);
        t = 64'(wide >> TAYLOR_SH);
        if (n[0]) sum = sum + longint'(t);
        else sum = sum - longint'(t);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) sum = 65536;
      tab[k] = 17'(sum);
    end
    return tab;
  endfunction

  localparam sq_tab_t SQ_TAB = build_sq_tab();

  // sine of an angle below 720 half-degrees
  function automatic logic signed [TRIG_W-1:0] sin_half(input logic [ANG_W-1:0] a);
    logic [1:0] q;
    logic [ANG_W-1:0] r;
    logic [16:0] v;
    if (a >= 10'd540) begin
      q = 2'd3; r = a - 10'd540;
    end else if (a >= 10'd360) begin
      q = 2'd2; r = a - 10'd360;
    end else if (a >= 10'd180) begin
      q = 2'd1; r = a - 10'd180;
    end else begin
      q = 2'd0; r = a;
    end
    v = q[0] ? SQ_TAB[8'(10'd180 - r)] : SQ_TAB[8'(r)];
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_half(input logic [ANG_W-1:0] a);
    logic [ANG_W:0] b;
    b = {1'b0, a} + 11'd180;
    if (b >= 11'd720) b = b - 11'd720;
    return sin_half(b[ANG_W-1:0]);
  endfunction

endpackage
`default_nettype wire

/* rtl/grid_ray_march_column_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_march_column_top: one screen column of a grid ray caster
// Marches a ray across a square wall grid and returns the wall slice.
// ----------------------------------------------------------------------------
// One request (a column index) takes the march and then a tail: one unit
// step of the ray per cycle in ST_MARCH until the stop point is caught,
// then ST_SQ_X, ST_SQ_Y and ST_SUM for the two squares and their sum,
// ST_SQRT for the bit-pair square root, ST_MUL_D and ST_DIV_CHK for the
// distance times cosine product and its range check, ST_DIV for the
// restoring divider unless the check saturates the height, ST_FINISH to
// post the result and ST_IDLE to take the next request. One multiplier,
// one subtractor-comparator for the root and one for the divider are shared
// through a small sequencer. in_stall stays high from acceptance until the
// result is handed to the output register; a waiting result does not block
// the next request. Configuration goes over an APB-style port, 64-bit
// registers at byte addresses 0, 8, 16, 24 and 32.
// ----------------------------------------------------------------------------
module grid_ray_march_column_top
  import grm_pkg::*;
#(
  parameter int CELL_SIZE    = CELL_SIZE_DEF,
  parameter int GRID_DIM     = GRID_DIM_DEF,
  parameter int SCREEN_ROWS  = SCREEN_ROWS_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF,
  localparam int H_W    = $clog2(SCREEN_ROWS + 1),
  localparam int TOP_W  = $clog2(SCREEN_ROWS / 2 + 1),
  localparam int LEFT_W = $clog2(COLUMN_WIDTH * 127 + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // APB-style configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [IDX_W-1:0]  ray_index,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [H_W-1:0]         column_height,
  output logic [TOP_W-1:0]       column_top,
  output logic [LEFT_W-1:0]      column_left,
  output logic [1:0]             wall_face
);

  // divider output width; 2^QB exceeds SCREEN_ROWS
  localparam int QB = $clog2(SCREEN_ROWS) + 1;
  localparam int CNT_W = 5;
  localparam int SQRT_STEPS = 29;
  localparam int RAD_W = 58;
  localparam int DIST_W = 29;
  // reciprocal for exact division of a 12-bit pixel by CELL_SIZE
  localparam int RECIP_SH = 21;
  localparam longint CELL_RECIP = (longint'(1) << RECIP_SH) / CELL_SIZE + 1;
  localparam logic [63:0] HNUM = 64'(SCREEN_ROWS * HEIGHT_SCALE) << 32;
  localparam logic signed [POS_W-1:0] POS_LIMIT = POS_W'(SCREEN_ROWS) <<< 16;

  // ---------------- configuration registers ----------------
  logic [ANG_W-1:0] view_angle;
  logic [9:0]       origin_x;
  logic [9:0]       origin_y;
  logic [63:0]      wall_map_low;
  logic [35:0]      wall_map_high;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_angle    <= '0;
      origin_x      <= 10'd100;
      origin_y      <= 10'd100;
      wall_map_low  <= '0;
      wall_map_high <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_VIEW:     view_angle    <= pwdata[ANG_W-1:0];
        REG_ORIGIN_X: origin_x      <= pwdata[9:0];
        REG_ORIGIN_Y: origin_y      <= pwdata[9:0];
        REG_MAP_LOW:  wall_map_low  <= pwdata;
        REG_MAP_HIGH: wall_map_high <= pwdata[35:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_VIEW:     prdata = 64'(view_angle);
      REG_ORIGIN_X: prdata = 64'(origin_x);
      REG_ORIGIN_Y: prdata = 64'(origin_y);
      REG_MAP_LOW:  prdata = wall_map_low;
      REG_MAP_HIGH: prdata = 64'(wall_map_high);
      default:      prdata = '0;
    endcase
  end

  // ---------------- helpers ----------------
  // floor(x / CELL_SIZE) for x below 4096
  function automatic logic [11:0] cell_div(input logic [11:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(CELL_RECIP);
    return p[RECIP_SH +: 12];
  endfunction

  function automatic logic pos_inside(input logic signed [POS_W-1:0] v);
    return (v > 0) && (v < POS_LIMIT);
  endfunction

  // stop point near a cell edge; negative always counts
  function automatic logic near_edge(input logic signed [POS_W-1:0] v);
    logic [11:0] x;
    logic [11:0] m;
    if (v < 0) return 1'b1;
    x = v[27:16];
    m = x - 12'(cell_div(x) * 12'(CELL_SIZE));
    return (m <= 12'd1) || (m >= 12'(CELL_SIZE - 1));
  endfunction

  // ---------------- datapath registers ----------------
  state_t state, state_next;

  logic signed [POS_W-1:0]  px, py;
  logic signed [TRIG_W-1:0] step_x, step_y;
  logic [16:0]              cs;
  logic [LEFT_W-1:0]        left_r;
  logic [DIST_W-1:0]        dx_abs, dy_abs;
  logic [RAD_W-1:0]         prod;
  logic [RAD_W-1:0]         rad, res, sbit;
  logic [CNT_W-1:0]         cnt;
  logic [63:0]              rem, dsh;
  logic [QB-1:0]            quo;
  logic [H_W-1:0]           hgt;

  // ---------------- request decode ----------------
  logic              in_acc;
  logic [11:0]       ang_sum;
  logic [ANG_W-1:0]  ang;
  logic [IDX_W-1:0]  off;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    ang_sum = 12'(view_angle) + 12'(720 - HALF_FAN + 1) + 12'(ray_index);
    if (ang_sum >= 12'd1440) ang = ANG_W'(ang_sum - 12'd1440);
    else if (ang_sum >= 12'd720) ang = ANG_W'(ang_sum - 12'd720);
    else ang = ANG_W'(ang_sum);
    if (ray_index <= IDX_W'(HALF_FAN - 1)) off = IDX_W'(HALF_FAN - 1) - ray_index;
    else off = ray_index - IDX_W'(HALF_FAN - 1);
  end

  // ---------------- march test ----------------
  logic [11:0] col, row;
  logic [11:0] cell_w;
  logic [7:0]  cell_num;
  logic        wall;
  logic        march_stop;
  logic [MAP_BITS-1:0] wall_map;

  assign wall_map = {wall_map_high, wall_map_low};

  always_comb begin
    col      = cell_div(px[27:16]);
    row      = cell_div(py[27:16]);
    cell_w   = 12'(row * 12'(GRID_DIM)) + col;
    cell_num = cell_w[7:0];
    if (col >= 12'(GRID_DIM) || row >= 12'(GRID_DIM)) wall = 1'b1;
    else if (cell_num >= 8'(MAP_BITS)) wall = 1'b1;
    else wall = wall_map[cell_num[6:0]];
    march_stop = !(pos_inside(px) && pos_inside(py) && !wall);
  end

  logic signed [POS_W-1:0] dx, dy;
  assign dx = px - (POS_W'(origin_x) <<< 16);
  assign dy = py - (POS_W'(origin_y) <<< 16);

  // ---------------- shared units ----------------
  logic [DIST_W-1:0] mul_a, mul_b;
  logic [RAD_W-1:0]  sq_try;
  logic              sq_ge;
  logic              div_ge;
  logic              out_free;

  assign sq_try   = res + sbit;
  assign sq_ge    = rad >= sq_try;
  assign div_ge   = rem >= dsh;
  assign out_free = !out_valid || !out_stall;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    mul_a      = dx_abs;
    mul_b      = dx_abs;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MARCH;
      ST_MARCH:   if (march_stop) state_next = ST_SQ_X;
      ST_SQ_X:    state_next = ST_SQ_Y;
      ST_SQ_Y: begin
        mul_a = dy_abs;
        mul_b = dy_abs;
        state_next = ST_SUM;
      end
      ST_SUM:     state_next = ST_SQRT;
      ST_SQRT:    if (cnt == '0) state_next = ST_MUL_D;
      ST_MUL_D: begin
        mul_a = res[DIST_W-1:0];
        mul_b = DIST_W'(cs);
        state_next = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        if (HNUM >= (64'(prod) << QB)) state_next = ST_FINISH;
        else state_next = ST_DIV;
      end
      ST_DIV:     if (cnt == '0) state_next = ST_FINISH;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod <= RAD_W'(mul_a * mul_b);
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          px     <= (POS_W'(origin_x) + POS_W'(START_OFFSET)) <<< 16;
          py     <= (POS_W'(origin_y) + POS_W'(START_OFFSET)) <<< 16;
          step_x <= sin_half(ang);
          step_y <= cos_half(ang);
          cs     <= 17'(cos_half(ANG_W'(off)));
          left_r <= LEFT_W'(COLUMN_WIDTH * ray_index);
        end
      end
      ST_MARCH: begin
        if (march_stop) begin
          dx_abs <= DIST_W'(dx < 0 ? -dx : dx);
          dy_abs <= DIST_W'(dy < 0 ? -dy : dy);
        end else begin
          px <= px + POS_W'(step_x);
          py <= py + POS_W'(step_y);
        end
      end
      ST_SQ_Y: rad <= prod;
      ST_SUM: begin
        rad  <= rad + prod;
        res  <= '0;
        sbit <= RAD_W'(1) << (2 * (SQRT_STEPS - 1));
        cnt  <= CNT_W'(SQRT_STEPS - 1);
      end
      ST_SQRT: begin
        if (sq_ge) begin
          rad <= rad - sq_try;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt - 1'b1;
      end
      ST_DIV_CHK: begin
        hgt <= H_W'(SCREEN_ROWS);
        rem <= HNUM;
        dsh <= 64'(prod) << (QB - 1);
        quo <= '0;
        cnt <= CNT_W'(QB - 1);
      end
      ST_DIV: begin
        if (div_ge) rem <= rem - dsh;
        quo <= {quo[QB-2:0], div_ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          if ({quo[QB-2:0], div_ge} > QB'(SCREEN_ROWS)) hgt <= H_W'(SCREEN_ROWS);
          else hgt <= H_W'({quo[QB-2:0], div_ge});
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      column_height <= hgt;
      column_top    <= TOP_W'((H_W'(SCREEN_ROWS) - hgt) >> 1);
      column_left   <= left_r;
      wall_face     <= near_edge(px) ? 2'd0 : (near_edge(py) ? 2'd1 : 2'd2);
    end
  end

endmodule
`default_nettype wire

/* rtl/grm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grm_checker: port-level assertions for the column ray marcher
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module grm_checker
  import grm_pkg::*;
#(
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  localparam int H_W   = $clog2(SCREEN_ROWS + 1),
  localparam int TOP_W = $clog2(SCREEN_ROWS / 2 + 1)
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [H_W-1:0]   column_height,
  input wire logic [TOP_W-1:0] column_top,
  input wire logic [1:0]       wall_face
);

  // a request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while block stays free");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (column_height <= H_W'(SCREEN_ROWS)))
    else $error("height above screen");

  a_top_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (column_top == TOP_W'((H_W'(SCREEN_ROWS) - column_height) >> 1)))
    else $error("top row does not match height");

  a_face_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wall_face != 2'd3))
    else $error("bad face code");

endmodule

bind grid_ray_march_column_top grm_checker #(.SCREEN_ROWS(SCREEN_ROWS)) u_grm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .column_height (column_height),
  .column_top    (column_top),
  .wall_face     (wall_face)
);
`default_nettype wire

/* sim/grm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_scoreboard: result predictor and scoreboard for the column ray marcher
// Tracks register writes, predicts each accepted request and compares the
// results in order.
// ----------------------------------------------------------------------------
module grm_scoreboard
  import grm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [6:0]        ray_index,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [9:0]        column_height,
  input  wire logic [8:0]        column_top,
  input  wire logic [10:0]       column_left,
  input  wire logic [1:0]        wall_face,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [9:0]  height;
    logic [8:0]  top;
    logic [10:0] left;
    logic [1:0]  face;
  } slice_t;

  localparam longint EDGE_Q16 = 640 * 65536;

  slice_t      slice_q[$];
  int          sine_q16[181];
  logic [9:0]  view_angle_r;
  logic [9:0]  origin_x_r;
  logic [9:0]  origin_y_r;
  logic [99:0] wall_bits;

  initial begin
    longint unsigned x, t;
    longint sum;
    for (int k = 0; k <= 180; k++) begin
      x = (longint'(k) * 64'd3373259426 + 64'd180) / 64'd360;
      t = x;
      sum = longint'(x);
      for (int n = 0; n < 8; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / longint'((2 * n + 2) * (2 * n + 3));
        sum = (n % 2 == 1) ? sum + longint'(t) : sum - longint'(t);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) / 16384;
      sine_q16[k] = (sum > 65536) ? 65536 : int'(sum);
    end
  end

  function automatic longint sine_of(input int a);
    int q, r;
    longint v;
    q = (a % 720) / 180;
    r = a % 180;
    v = (q % 2 == 1) ? sine_q16[180 - r] : sine_q16[r];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint cosine_of(input int a);
    return sine_of((a % 720) + 180);
  endfunction

  function automatic logic blocked(input longint px, input longint py);
    longint col, row, cell_num;
    col = (px >>> 16) / 64;
    row = (py >>> 16) / 64;
    if (col >= 10 || row >= 10) return 1'b1;
    cell_num = row * 10 + col;
    return wall_bits[cell_num];
  endfunction

  function automatic logic near_line(input longint v);
    longint m;
    if (v < 0) return 1'b1;
    m = (v >>> 16) % 64;
    return m <= 1 || m >= 63;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // cast one ray with the current registers
  function automatic slice_t cast_column(input logic [6:0] idx);
    slice_t s;
    int ang, off;
    longint sx, cy, px, py, dx, dy;
    longint unsigned dist_q, den, h;
    ang = (int'(view_angle_r) + 720 - 60 + int'(idx) + 1) % 720;
    sx = sine_of(ang);
    cy = cosine_of(ang);
    px = (longint'(origin_x_r) + 5) * 65536;
    py = (longint'(origin_y_r) + 5) * 65536;
    while (px > 0 && px < EDGE_Q16 && py > 0 && py < EDGE_Q16 && !blocked(px, py)) begin
      px += sx;
      py += cy;
    end
    dx = px - longint'(origin_x_r) * 65536;
    dy = py - longint'(origin_y_r) * 65536;
    dist_q = root_floor(longint'(dx * dx) + longint'(dy * dy));
    off = 59 - int'(idx);
    if (off < 0) off = -off;
    den = dist_q * longint'(cosine_of(off));
    if (den == 0) h = 640;
    else begin
      h = (64'd19200 << 32) / den;
      if (h > 640) h = 640;
    end
    s.height = 10'(h);
    s.top = 9'((640 - h) / 2);
    s.left = 11'(10 * int'(idx));
    s.face = near_line(px) ? 2'd0 : (near_line(py) ? 2'd1 : 2'd2);
    return s;
  endfunction

  assign pending = slice_q.size();

  always @(posedge clk) begin
    slice_t want, got;
    if (rst) begin
      view_angle_r <= 10'd0;
      origin_x_r <= 10'd100;
      origin_y_r <= 10'd100;
      wall_bits <= '0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_VIEW:     view_angle_r <= pwdata[9:0];
          REG_ORIGIN_X: origin_x_r <= pwdata[9:0];
          REG_ORIGIN_Y: origin_y_r <= pwdata[9:0];
          REG_MAP_LOW:  wall_bits[63:0] <= pwdata;
          REG_MAP_HIGH: wall_bits[99:64] <= pwdata[35:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) slice_q.push_back(cast_column(ray_index));
      if (out_valid && !out_stall) begin
        got = '{column_height, column_top, column_left, wall_face};
        if (slice_q.size() == 0) begin
          $display("%0t: unexpected result h=%0d top=%0d left=%0d face=%0d",
                   $time, got.height, got.top, got.left, got.face);
          fail_count++;
        end else begin
          want = slice_q.pop_front();
          if (got.height !== want.height) begin
            $display("%0t: column_height expected %0d got %0d", $time, want.height, got.height);
            fail_count++;
          end
          if (got.top !== want.top) begin
            $display("%0t: column_top expected %0d got %0d", $time, want.top, got.top);
            fail_count++;
          end
          if (got.left !== want.left) begin
            $display("%0t: column_left expected %0d got %0d", $time, want.left, got.left);
            fail_count++;
          end
          if (got.face !== want.face) begin
            $display("%0t: wall_face expected %0d got %0d", $time, want.face, got.face);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the column ray marcher
// Directed and random column requests over many viewer and map settings,
// with bursty requests, a patterned result stall and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import grm_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [6:0]        ray_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [9:0]        column_height;
  logic [8:0]        column_top;
  logic [10:0]       column_left;
  logic [1:0]        wall_face;
  int                fail_count;
  int                pending;

  // set by the stimulus once; the stall process runs the hold itself
  logic              hold_req = 1'b0;

  always #5 clk = ~clk;

  grid_ray_march_column_top i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .ray_index,
    .out_valid, .out_stall, .column_height, .column_top, .column_left, .wall_face
  );

  grm_scoreboard i_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .ray_index,
    .out_valid, .out_stall, .column_height, .column_top, .column_left, .wall_face,
    .fail_count, .pending
  );

  // Result stall: a mode counter switches the pattern at random between free
  // flow, light and heavy stalling. One long hold lets the block fill up.
  always @(posedge clk) begin
    static int mode = 0;
    static int mode_left = 0;
    static int hold_left = 0;
    static bit hold_done = 0;
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 6000;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = 200;
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  int burst_left = 0;

  // two-phase register write
  task automatic reg_write(input logic [2:0] reg_idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // offer one request; in_stall is stable at the falling edge
  task automatic send_column(input logic [6:0] idx);
    bit taken;
    in_valid <= 1'b1;
    ray_index <= idx;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      burst_left = $urandom_range(0, 19);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // settle: requests off and every result back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_view(input int view, input int ox, input int oy, input logic [99:0] map);
    drain();
    reg_write(REG_VIEW, 64'(view));
    reg_write(REG_ORIGIN_X, 64'(ox));
    reg_write(REG_ORIGIN_Y, 64'(oy));
    reg_write(REG_MAP_LOW, map[63:0]);
    reg_write(REG_MAP_HIGH, 64'(map[99:64]));
  endtask

  function automatic logic [99:0] random_map(input int density);
    logic [99:0] m;
    for (int i = 0; i < 100; i++) m[i] = ($urandom_range(0, 99) < density);
    return m;
  endfunction

  initial begin
    logic [99:0] map;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset registers: empty map, rays run to the screen edge
    send_column(7'd0);
    send_column(7'd59);
    send_column(7'd60);
    send_column(7'd119);
    send_column(7'd127);
    // extremes of heading and position, negative stop coordinates
    set_view(719, 0, 0, '0);
    send_column(7'd0);
    send_column(7'd127);
    send_column(7'd64);
    // start beyond the screen edge: no step is taken
    set_view(360, 639, 639, '0);
    send_column(7'd30);
    send_column(7'd90);
    // start inside a wall, all cells solid
    set_view(180, 320, 320, '1);
    send_column(7'd1);
    send_column(7'd118);
    // walled border with an open interior, all bit positions of both maps
    map = '0;
    for (int i = 0; i < 10; i++) begin
      map[i] = 1'b1; map[90 + i] = 1'b1; map[10 * i] = 1'b1; map[10 * i + 9] = 1'b1;
    end
    set_view(540, 300, 300, map);
    for (int i = 0; i < 8; i++) send_column(7'(i * 17));
    set_view(90, 639, 0, ~map);
    send_column(7'd45);
    send_column(7'd100);

    // random phases; most maps have a border so rays hit real walls
    for (int ph = 0; ph < 12; ph++) begin
      map = random_map($urandom_range(0, 4) == 0 ? $urandom_range(0, 100)
                                                 : $urandom_range(5, 30));
      if ($urandom_range(0, 3) != 0)
        for (int i = 0; i < 10; i++) begin
          map[i] = 1'b1; map[90 + i] = 1'b1; map[10 * i] = 1'b1; map[10 * i + 9] = 1'b1;
        end
      set_view($urandom_range(0, 719), $urandom_range(0, 639), $urandom_range(0, 639), map);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 48; n++) send_column(7'($urandom_range(0, 127)));
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/grm_pkg.sv
rtl/grid_ray_march_column_top.sv
rtl/grm_checker.sv
sim/grm_checker.sv
sim/tb_top.sv
